// ----- design/hcb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Huffman code builder: request and result payload types.
// No dependencies.
package hcb_pkg;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned FREQ_W  = 24;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned CODE_W  = 31;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BUILD = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
    } hcb_in_t;

    typedef struct packed {
        logic              [SYM_W-1:0]  out_symbol;
        logic              [LEN_W-1:0]  code_length;
        logic              [CODE_W-1:0] code_bits;
        logic                           last_code;
        logic                           overflow;
    } hcb_out_t;

endpackage

// ----- design/hcb_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hcb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/huffman_code_builder.sv -----
`timescale 1ns / 1ps
// Huffman code builder top level: load sequencer, heap sift unit and tree walk.
// Depends on hcb_pkg and hcb_ram.
//
// Leaf requests (action 0) are taken one per cycle and written straight into
// the heap memory in load order; a leaf beyond SYMBOLS is dropped and flagged.
// A build request (action 1) holds s_ready low while one shared sift unit
// heapifies the leaves bottom-up, then pairs off the two lightest nodes until
// one is left (first extracted becomes the left child, ties never move).
// Each sift-down level reads the left child, reads the right child, then
// compares and writes back; each sift-up level reads the parent, then
// compares and writes back. The depth-first walk reads the child memory
// at each internal node, the symbol memory at each leaf and the stack
// memory on each pop, all with registered reads. One code result is then
// emitted per leaf, left-first; the last carries last_code. The result
// register lets a result wait on m_ready while new leaves load. A build
// with no leaves emits nothing and leaves the overflow flag as it was.
module huffman_code_builder #(
    parameter int unsigned SYMBOLS   = 32,
    parameter int unsigned FREQ_BITS = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hcb_pkg::hcb_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output hcb_pkg::hcb_out_t m_data
);
    import hcb_pkg::*;

    localparam int unsigned NODES = 2 * SYMBOLS - 1;
    localparam int unsigned NIW   = $clog2(NODES);
    localparam int unsigned HA    = $clog2(SYMBOLS);
    localparam int unsigned CW    = $clog2(SYMBOLS) + 2;
    localparam int unsigned LW    = $clog2(SYMBOLS + 1);
    localparam int unsigned FB    = (FREQ_BITS < FREQ_W) ? FREQ_BITS : FREQ_W;
    localparam int unsigned WW    = FB + $clog2(SYMBOLS);
    localparam int unsigned SW    = NIW + LEN_W + CODE_W;

    typedef struct packed {
        logic [NIW-1:0] node;
        logic [WW-1:0]  w;
    } heap_t;

    typedef enum logic [4:0] {
        S_IDLE, S_HFY_RD, S_HFY_LD, S_SD_L, S_SD_R, S_SD_CMP,
        S_TM0, S_TM1, S_TM2, S_MERGE, S_JOIN, S_PU_CHK, S_PU_CMP,
        S_ROOT, S_WALK, S_CHILD, S_EMIT, S_POP
    } state_t;

    typedef enum logic [1:0] {
        PH_HEAPIFY, PH_TAKE_A, PH_TAKE_B
    } phase_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]   leaf_cnt_reg, leaf_cnt_next;
    logic            drop_reg, drop_next;
    logic [NIW-1:0]  nxt_reg, nxt_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    heap_t           x_reg, x_next;
    heap_t           lft_reg, lft_next;
    heap_t           top_reg, top_next;
    heap_t           a_reg, a_next;
    heap_t           new_reg, new_next;
    logic [NIW-1:0]  cur_node_reg, cur_node_next;
    logic [LEN_W-1:0]  cur_depth_reg, cur_depth_next;
    logic [CODE_W-1:0] cur_path_reg, cur_path_next;
    logic [HA:0]     sp_reg, sp_next;
    logic            m_valid_reg, m_valid_next;
    hcb_out_t        m_data_reg, m_data_next;

    // memory ports
    logic            heap_we, heap_re;
    logic [HA-1:0]   heap_waddr, heap_raddr;
    heap_t           heap_wdata, heap_rdata;
    logic            sym_we, sym_re;
    logic [HA-1:0]   sym_waddr, sym_raddr;
    logic [SYM_W-1:0] sym_wdata, sym_rdata;
    logic            kid_we, kid_re;
    logic [NIW-1:0]  kid_waddr, kid_raddr;
    logic [2*NIW-1:0] kid_wdata, kid_rdata;
    logic            stk_we, stk_re;
    logic [HA-1:0]   stk_waddr, stk_raddr;
    logic [SW-1:0]   stk_wdata, stk_rdata;

    logic [CW-1:0]   lchild, rchild, parent;
    logic            sift_done;
    heap_t           best;
    logic [CW-1:0]   best_idx;
    logic            is_leaf;

    assign lchild  = (pos_reg << 1) + CW'(1);
    assign rchild  = (pos_reg << 1) + CW'(2);
    assign parent  = (idx_reg - CW'(1)) >> 1;
    assign is_leaf = CW'(cur_node_reg) < CW'(leaf_cnt_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        leaf_cnt_next  = leaf_cnt_reg;
        drop_next      = drop_reg;
        nxt_next       = nxt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        lft_next       = lft_reg;
        top_next       = top_reg;
        a_next         = a_reg;
        new_next       = new_reg;
        cur_node_next  = cur_node_reg;
        cur_depth_next = cur_depth_reg;
        cur_path_next  = cur_path_reg;
        sp_next        = sp_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        heap_we = 1'b0; heap_waddr = '0; heap_wdata = x_reg;
        heap_re = 1'b0; heap_raddr = '0;
        sym_we  = 1'b0; sym_waddr  = '0; sym_wdata  = s_data.symbol;
        sym_re  = 1'b0; sym_raddr  = cur_node_reg[HA-1:0];
        kid_we  = 1'b0; kid_waddr  = nxt_reg; kid_wdata = {a_reg.node, top_reg.node};
        kid_re  = 1'b0; kid_raddr  = cur_node_reg;
        stk_we  = 1'b0; stk_waddr  = sp_reg[HA-1:0];
        stk_wdata = '0;
        stk_re  = 1'b0; stk_raddr  = '0;

        sift_done = 1'b0;
        best      = x_reg;
        best_idx  = pos_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACT_LOAD) begin
                        if (CW'(leaf_cnt_reg) < CW'(SYMBOLS)) begin
                            heap_we    = 1'b1;
                            heap_waddr = leaf_cnt_reg[HA-1:0];
                            heap_wdata.node = NIW'(leaf_cnt_reg);
                            heap_wdata.w    = WW'(s_data.frequency[FB-1:0]);
                            sym_we     = 1'b1;
                            sym_waddr  = leaf_cnt_reg[HA-1:0];
                            leaf_cnt_next = leaf_cnt_reg + LW'(1);
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else if (leaf_cnt_reg != '0) begin
                        cnt_next = CW'(leaf_cnt_reg);
                        nxt_next = NIW'(leaf_cnt_reg);
                        if (leaf_cnt_reg == LW'(1)) begin
                            state_next = S_MERGE;
                        end else begin
                            idx_next   = (CW'(leaf_cnt_reg) - CW'(2)) >> 1;
                            state_next = S_HFY_RD;
                        end
                    end
                end
            end
            S_HFY_RD: begin
                heap_re    = 1'b1;
                heap_raddr = idx_reg[HA-1:0];
                state_next = S_HFY_LD;
            end
            S_HFY_LD: begin
                x_next     = heap_rdata;
                pos_next   = idx_reg;
                phase_next = PH_HEAPIFY;
                state_next = S_SD_L;
            end
            S_SD_L: begin
                if (lchild < cnt_reg) begin
                    heap_re    = 1'b1;
                    heap_raddr = lchild[HA-1:0];
                    state_next = S_SD_R;
                end else begin
                    heap_we    = 1'b1;
                    heap_waddr = pos_reg[HA-1:0];
                    sift_done  = 1'b1;
                end
            end
            S_SD_R: begin
                lft_next = heap_rdata;
                if (rchild < cnt_reg) begin
                    heap_re    = 1'b1;
                    heap_raddr = rchild[HA-1:0];
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (lft_reg.w < x_reg.w) begin
                    best     = lft_reg;
                    best_idx = lchild;
                end
                if (rchild < cnt_reg && heap_rdata.w < best.w) begin
                    best     = heap_rdata;
                    best_idx = rchild;
                end
                heap_we    = 1'b1;
                heap_waddr = pos_reg[HA-1:0];
                heap_wdata = best;
                if (best_idx == pos_reg) begin
                    sift_done = 1'b1;
                end else begin
                    pos_next   = best_idx;
                    state_next = S_SD_L;
                end
            end
            S_TM0: begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_next = S_TM1;
            end
            S_TM1: begin
                top_next   = heap_rdata;
                heap_re    = 1'b1;
                heap_raddr = HA'(cnt_reg - CW'(1));
                state_next = S_TM2;
            end
            S_TM2: begin
                x_next     = heap_rdata;
                cnt_next   = cnt_reg - CW'(1);
                pos_next   = '0;
                state_next = S_SD_L;
            end
            S_MERGE: begin
                if (cnt_reg > CW'(1)) begin
                    phase_next = PH_TAKE_A;
                    state_next = S_TM0;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = '0;
                    state_next = S_ROOT;
                end
            end
            S_JOIN: begin
                kid_we        = 1'b1;
                new_next.node = nxt_reg;
                new_next.w    = WW'(a_reg.w + top_reg.w);
                idx_next      = cnt_reg;
                cnt_next      = cnt_reg + CW'(1);
                nxt_next      = nxt_reg + NIW'(1);
                state_next    = S_PU_CHK;
            end
            S_PU_CHK: begin
                if (idx_reg == '0) begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    heap_wdata = new_reg;
                    state_next = S_MERGE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = parent[HA-1:0];
                    state_next = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg[HA-1:0];
                if (new_reg.w < heap_rdata.w) begin
                    heap_wdata = heap_rdata;
                    idx_next   = parent;
                    state_next = S_PU_CHK;
                end else begin
                    heap_wdata = new_reg;
                    state_next = S_MERGE;
                end
            end
            S_ROOT: begin
                cur_node_next  = heap_rdata.node;
                cur_depth_next = '0;
                cur_path_next  = '0;
                sp_next        = '0;
                state_next     = S_WALK;
            end
            S_WALK: begin
                if (is_leaf) begin
                    sym_re     = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    kid_re     = 1'b1;
                    state_next = S_CHILD;
                end
            end
            S_CHILD: begin
                // push the right branch, descend left
                stk_we    = 1'b1;
                stk_wdata = {kid_rdata[NIW-1:0], cur_depth_reg + LEN_W'(1),
                             cur_path_reg[CODE_W-2:0], 1'b1};
                sp_next        = sp_reg + (HA+1)'(1);
                cur_node_next  = kid_rdata[2*NIW-1:NIW];
                cur_depth_next = cur_depth_reg + LEN_W'(1);
                cur_path_next  = {cur_path_reg[CODE_W-2:0], 1'b0};
                state_next     = S_WALK;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.out_symbol  = sym_rdata;
                    m_data_next.code_length = cur_depth_reg;
                    m_data_next.code_bits   = cur_path_reg;
                    m_data_next.last_code   = (sp_reg == '0);
                    m_data_next.overflow    = drop_reg;
                    if (sp_reg == '0) begin
                        leaf_cnt_next = '0;
                        drop_next     = 1'b0;
                        cnt_next      = '0;
                        state_next    = S_IDLE;
                    end else begin
                        stk_re     = 1'b1;
                        stk_raddr  = HA'(sp_reg - (HA+1)'(1));
                        sp_next    = sp_reg - (HA+1)'(1);
                        state_next = S_POP;
                    end
                end
            end
            S_POP: begin
                {cur_node_next, cur_depth_next, cur_path_next} = stk_rdata;
                state_next = S_WALK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // hand back to whoever started the sift
        if (sift_done) begin
            case (phase_reg)
                PH_HEAPIFY: begin
                    if (idx_reg == '0) begin
                        state_next = S_MERGE;
                    end else begin
                        idx_next   = idx_reg - CW'(1);
                        state_next = S_HFY_RD;
                    end
                end
                PH_TAKE_A: begin
                    a_next     = top_reg;
                    phase_next = PH_TAKE_B;
                    state_next = S_TM0;
                end
                PH_TAKE_B: begin
                    state_next = S_JOIN;
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_HEAPIFY;
            cnt_reg      <= '0;
            leaf_cnt_reg <= '0;
            drop_reg     <= 1'b0;
            sp_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            leaf_cnt_reg <= leaf_cnt_next;
            drop_reg     <= drop_next;
            sp_reg       <= sp_next;
            m_valid_reg  <= m_valid_next;
        end
        nxt_reg       <= nxt_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        x_reg         <= x_next;
        lft_reg       <= lft_next;
        top_reg       <= top_next;
        a_reg         <= a_next;
        new_reg       <= new_next;
        cur_node_reg  <= cur_node_next;
        cur_depth_reg <= cur_depth_next;
        cur_path_reg  <= cur_path_next;
        m_data_reg    <= m_data_next;
    end

    hcb_ram #(.WIDTH($bits(heap_t)), .DEPTH(SYMBOLS)) u_heap_ram (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .re(heap_re), .raddr(heap_raddr), .rdata(heap_rdata)
    );

    hcb_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_sym_ram (
        .aclk(aclk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
        .re(sym_re), .raddr(sym_raddr), .rdata(sym_rdata)
    );

    hcb_ram #(.WIDTH(2 * NIW), .DEPTH(NODES)) u_kid_ram (
        .aclk(aclk), .we(kid_we), .waddr(kid_waddr), .wdata(kid_wdata),
        .re(kid_re), .raddr(kid_raddr), .rdata(kid_rdata)
    );

    hcb_ram #(.WIDTH(SW), .DEPTH(SYMBOLS)) u_stk_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

endmodule

// ----- design/hcb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the Huffman code builder, bound to the top level.
// Depends on hcb_pkg.
module hcb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input hcb_pkg::hcb_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input hcb_pkg::hcb_out_t m_data
);
    import hcb_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a result is only loaded while a build holds the request side
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared outside a build");

    // a zero-length code only comes from a lone leaf, the sole result
    a_lone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.code_length == '0 |-> m_data.last_code && m_data.code_bits == '0)
        else $error("zero-length code not alone");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
